### rtl/fgq_pkg.sv
// fgq_pkg: shared constants, opcodes and transfer structs of face_geometry_query.
// No dependencies.
package fgq_pkg;

	localparam int NODE_DEPTH = 1024;
	localparam int FACE_DEPTH = 1024;
	localparam int CELL_DEPTH = 1024;

	// queue between lookup front and arithmetic back; power of two
	localparam int QDEPTH = 8;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	localparam int SQ_STEPS  = 34;
	localparam int DIV_STEPS = 32;

	localparam logic [1:0] OP_NODE  = 2'd0;
	localparam logic [1:0] OP_FACE  = 2'd1;
	localparam logic [1:0] OP_CENT  = 2'd2;
	localparam logic [1:0] OP_QUERY = 2'd3;

	localparam logic signed [31:0] NORM_ONE = 32'sh4000_0000;

	typedef struct packed {
		logic signed [31:0] ax;
		logic signed [31:0] ay;
		logic signed [31:0] bx;
		logic signed [31:0] by;
		logic signed [31:0] gx;
		logic signed [31:0] gy;
		logic signed [10:0] nbr;
	} qitem_t;

	typedef struct packed {
		logic   vld;
		qitem_t item;
	} qpush_t;

	typedef struct packed {
		logic signed [31:0] mx;
		logic signed [31:0] my;
		logic signed [32:0] ex;
		logic signed [32:0] ey;
		logic               neg_x;
		logic               neg_y;
		logic               degen;
		logic signed [10:0] nbr;
		logic [32:0]        kx;
		logic [32:0]        ky;
		logic [32:0]        len;
	} tag_t;

endpackage

### rtl/fgq_ram.sv
// fgq_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module fgq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/fgq_front.sv
// fgq_front: accepts items, performs table writes and query lookups in order.
// Depends on fgq_pkg and fgq_ram; pushes query operands to fgq_queue.
module fgq_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  valid,
	output logic                  stall,
	input  logic [1:0]            opcode,
	input  logic [9:0]            index,
	input  logic signed [31:0]    coord_x,
	input  logic signed [31:0]    coord_y,
	input  logic [9:0]            node_a,
	input  logic [9:0]            node_b,
	input  logic signed [10:0]    cell_a,
	input  logic signed [10:0]    cell_b,
	input  logic [9:0]            face_id,
	input  logic [9:0]            owner_cell,
	input  logic [fgq_pkg::QCW-1:0] q_count,
	output fgq_pkg::qpush_t       push
);
	import fgq_pkg::*;

	logic               accept;
	logic               vld_s1, vld_s2, vld_s3;
	logic [1:0]         op_s1, op_s2, op_s3;
	logic [9:0]         idx_s1, idx_s2;
	logic signed [31:0] cx_s1, cy_s1, cx_s2, cy_s2;
	logic [9:0]         na_s1, nb_s1;
	logic signed [10:0] ca_s1, cb_s1;
	logic [9:0]         face_s1;
	logic [9:0]         own_s1, own_s2, own_s3;
	logic signed [10:0] c1_s3, c2_s3;
	logic [41:0]        face_rd;
	logic [63:0]        node0_rd, node1_rd, cent_rd;
	logic [1:0]         nq;
	logic [QCW:0]       credit;

	assign accept = valid && !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= accept;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		op_s1   <= opcode;
		idx_s1  <= index;
		cx_s1   <= coord_x;
		cy_s1   <= coord_y;
		na_s1   <= node_a;
		nb_s1   <= node_b;
		ca_s1   <= cell_a;
		cb_s1   <= cell_b;
		face_s1 <= face_id;
		own_s1  <= owner_cell;
		op_s2   <= op_s1;
		idx_s2  <= idx_s1;
		cx_s2   <= cx_s1;
		cy_s2   <= cy_s1;
		own_s2  <= own_s1;
		op_s3   <= op_s2;
		own_s3  <= own_s2;
		c1_s3   <= face_rd[21:11];
		c2_s3   <= face_rd[10:0];
	end

	fgq_ram #(.WIDTH(42), .DEPTH(FACE_DEPTH)) u_face (
		.clk   (clk),
		.we    (vld_s1 && op_s1 == OP_FACE),
		.waddr (idx_s1),
		.wdata ({na_s1, nb_s1, ca_s1, cb_s1}),
		.raddr (face_s1),
		.rdata (face_rd)
	);

	// two copies of the node table so both face ends are read in the same cycle
	fgq_ram #(.WIDTH(64), .DEPTH(NODE_DEPTH)) u_node0 (
		.clk   (clk),
		.we    (vld_s2 && op_s2 == OP_NODE),
		.waddr (idx_s2),
		.wdata ({cx_s2, cy_s2}),
		.raddr (face_rd[41:32]),
		.rdata (node0_rd)
	);

	fgq_ram #(.WIDTH(64), .DEPTH(NODE_DEPTH)) u_node1 (
		.clk   (clk),
		.we    (vld_s2 && op_s2 == OP_NODE),
		.waddr (idx_s2),
		.wdata ({cx_s2, cy_s2}),
		.raddr (face_rd[31:22]),
		.rdata (node1_rd)
	);

	fgq_ram #(.WIDTH(64), .DEPTH(CELL_DEPTH)) u_cent (
		.clk   (clk),
		.we    (vld_s2 && op_s2 == OP_CENT),
		.waddr (idx_s2),
		.wdata ({cx_s2, cy_s2}),
		.raddr (own_s2),
		.rdata (cent_rd)
	);

	always_comb begin
		push.vld      = vld_s3 && op_s3 == OP_QUERY;
		push.item.ax  = node0_rd[63:32];
		push.item.ay  = node0_rd[31:0];
		push.item.bx  = node1_rd[63:32];
		push.item.by  = node1_rd[31:0];
		push.item.gx  = cent_rd[63:32];
		push.item.gy  = cent_rd[31:0];
		push.item.nbr = (c1_s3 != $signed({1'b0, own_s3})) ? c1_s3 : c2_s3;
	end

	// credit: every query in flight owns a queue slot
	assign nq = 2'(vld_s1 && op_s1 == OP_QUERY) + 2'(vld_s2 && op_s2 == OP_QUERY)
		+ 2'(vld_s3 && op_s3 == OP_QUERY);
	assign credit = {1'b0, q_count} + (QCW + 1)'(nq);
	assign stall  = credit >= (QCW + 1)'(QDEPTH);

endmodule

### rtl/fgq_queue.sv
// fgq_queue: short first-word-fall-through queue of query operands.
// Depends on fgq_pkg.
module fgq_queue (
	input  logic                    clk,
	input  logic                    arst_n,
	input  fgq_pkg::qpush_t         push,
	input  logic                    pop,
	output logic                    out_vld,
	output fgq_pkg::qitem_t         out_item,
	output logic [fgq_pkg::QCW-1:0] count
);
	import fgq_pkg::*;

	qitem_t           mem_q [QDEPTH];
	logic [QAW-1:0]   wptr_q, rptr_q;
	logic [QCW-1:0]   cnt_q;
	logic             do_pop;

	assign do_pop   = pop && cnt_q != '0;
	assign out_vld  = cnt_q != '0;
	assign out_item = mem_q[rptr_q];
	assign count    = cnt_q;

	always_ff @(posedge clk) begin
		if (push.vld) begin
			mem_q[wptr_q] <= push.item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push.vld) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (do_pop) begin
				rptr_q <= rptr_q + 1'b1;
			end
			cnt_q <= cnt_q + QCW'(push.vld) - QCW'(do_pop);
		end
	end

endmodule

### rtl/fgq_sqrt.sv
// fgq_sqrt: two-lane pipelined round-to-nearest integer square root, one bit per stage.
// Depends on fgq_pkg; carries a tag_t alongside.
module fgq_sqrt (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [65:0]       s_a,
	input  logic [65:0]       s_b,
	input  fgq_pkg::tag_t     in_tag,
	output logic              out_vld,
	output logic [33:0]       root_a,
	output logic [33:0]       root_b,
	output fgq_pkg::tag_t     out_tag
);
	import fgq_pkg::*;

	logic [66:0] rem_a_s  [0:SQ_STEPS];
	logic [66:0] rem_b_s  [0:SQ_STEPS];
	logic [33:0] rt_a_s   [0:SQ_STEPS];
	logic [33:0] rt_b_s   [0:SQ_STEPS];
	tag_t        tag_s    [0:SQ_STEPS];
	logic        vld_s    [0:SQ_STEPS];

	assign rem_a_s[0] = {1'b0, s_a};
	assign rem_b_s[0] = {1'b0, s_b};
	assign rt_a_s[0]  = '0;
	assign rt_b_s[0]  = '0;
	assign tag_s[0]   = in_tag;
	assign vld_s[0]   = in_vld;

	for (genvar g = 0; g < SQ_STEPS; g++) begin : g_step
		localparam int B = SQ_STEPS - 1 - g;
		logic [68:0] ta, tb;

		always_comb begin
			ta = (69'(rt_a_s[g]) << (B + 1)) | (69'(1) << (2 * B));
			tb = (69'(rt_b_s[g]) << (B + 1)) | (69'(1) << (2 * B));
		end

		always_ff @(posedge clk) begin
			if (en) begin
				tag_s[g+1] <= tag_s[g];
				if ({2'b0, rem_a_s[g]} >= ta) begin
					rem_a_s[g+1] <= rem_a_s[g] - ta[66:0];
					rt_a_s[g+1]  <= rt_a_s[g] | (34'(1) << B);
				end else begin
					rem_a_s[g+1] <= rem_a_s[g];
					rt_a_s[g+1]  <= rt_a_s[g];
				end
				if ({2'b0, rem_b_s[g]} >= tb) begin
					rem_b_s[g+1] <= rem_b_s[g] - tb[66:0];
					rt_b_s[g+1]  <= rt_b_s[g] | (34'(1) << B);
				end else begin
					rem_b_s[g+1] <= rem_b_s[g];
					rt_b_s[g+1]  <= rt_b_s[g];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (en) begin
				vld_s[g+1] <= vld_s[g];
			end
		end
	end

	// round up when s exceeds r*r + r
	always_ff @(posedge clk) begin
		if (en) begin
			root_a  <= rt_a_s[SQ_STEPS] + 34'(rem_a_s[SQ_STEPS] > {33'b0, rt_a_s[SQ_STEPS]});
			root_b  <= rt_b_s[SQ_STEPS] + 34'(rem_b_s[SQ_STEPS] > {33'b0, rt_b_s[SQ_STEPS]});
			out_tag <= tag_s[SQ_STEPS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= vld_s[SQ_STEPS];
		end
	end

endmodule

### rtl/fgq_div.sv
// fgq_div: two-lane pipelined restoring divider, round(mag * 2^30 / den), one bit per stage.
// Depends on fgq_pkg; carries a tag_t alongside. Requires mag <= den.
module fgq_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_vld,
	input  logic [32:0]       mag_a,
	input  logic [32:0]       mag_b,
	input  logic [33:0]       den,
	input  fgq_pkg::tag_t     in_tag,
	output logic              out_vld,
	output logic [30:0]       q_a,
	output logic [30:0]       q_b,
	output fgq_pkg::tag_t     out_tag
);
	import fgq_pkg::*;

	logic [34:0] rem_a_s [0:DIV_STEPS];
	logic [34:0] rem_b_s [0:DIV_STEPS];
	logic [31:0] qa_s    [0:DIV_STEPS];
	logic [31:0] qb_s    [0:DIV_STEPS];
	logic [33:0] den_s   [0:DIV_STEPS];
	tag_t        tag_s   [0:DIV_STEPS];
	logic        vld_s   [0:DIV_STEPS];
	logic [32:0] ra, rb;

	assign rem_a_s[0] = {2'b0, mag_a};
	assign rem_b_s[0] = {2'b0, mag_b};
	assign qa_s[0]    = '0;
	assign qb_s[0]    = '0;
	assign den_s[0]   = den;
	assign tag_s[0]   = in_tag;
	assign vld_s[0]   = in_vld;

	for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
		localparam int B = DIV_STEPS - 1 - g;
		logic [34:0] ta, tb;

		always_comb begin
			ta = (g == 0) ? rem_a_s[g] : (rem_a_s[g] << 1);
			tb = (g == 0) ? rem_b_s[g] : (rem_b_s[g] << 1);
		end

		always_ff @(posedge clk) begin
			if (en) begin
				den_s[g+1] <= den_s[g];
				tag_s[g+1] <= tag_s[g];
				if (ta >= {1'b0, den_s[g]}) begin
					rem_a_s[g+1] <= ta - {1'b0, den_s[g]};
					qa_s[g+1]    <= qa_s[g] | (32'(1) << B);
				end else begin
					rem_a_s[g+1] <= ta;
					qa_s[g+1]    <= qa_s[g];
				end
				if (tb >= {1'b0, den_s[g]}) begin
					rem_b_s[g+1] <= tb - {1'b0, den_s[g]};
					qb_s[g+1]    <= qb_s[g] | (32'(1) << B);
				end else begin
					rem_b_s[g+1] <= tb;
					qb_s[g+1]    <= qb_s[g];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (en) begin
				vld_s[g+1] <= vld_s[g];
			end
		end
	end

	// quotient carries one extra fraction bit; halve with round half up
	assign ra = {1'b0, qa_s[DIV_STEPS]} + 33'd1;
	assign rb = {1'b0, qb_s[DIV_STEPS]} + 33'd1;

	always_ff @(posedge clk) begin
		if (en) begin
			q_a     <= ra[31:1];
			q_b     <= rb[31:1];
			out_tag <= tag_s[DIV_STEPS];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld <= 1'b0;
		end else if (en) begin
			out_vld <= vld_s[DIV_STEPS];
		end
	end

endmodule

### rtl/face_geometry_query.sv
// face_geometry_query: an input transfer passes 3 lookup stages, the queue, 6 setup
// stages, 35 square-root stages, 33 divider stages and 3 output stages to its result.
// Throughput one item per cycle unless stalled; write items give no result.
// The arithmetic back end holds as one on output stall; the queue absorbs the lookup front.
// Reset clears valid bits, queue pointers and count only; tables undefined until written.
// Depends on fgq_pkg, fgq_front, fgq_queue, fgq_sqrt, fgq_div.
module face_geometry_query (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [1:0]         opcode,
	input  logic [9:0]         index,
	input  logic signed [31:0] coord_x,
	input  logic signed [31:0] coord_y,
	input  logic [9:0]         node_a,
	input  logic [9:0]         node_b,
	input  logic signed [10:0] cell_a,
	input  logic signed [10:0] cell_b,
	input  logic [9:0]         face_id,
	input  logic [9:0]         owner_cell,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output logic signed [31:0] mid_x,
	output logic signed [31:0] mid_y,
	output logic [32:0]        face_length,
	output logic signed [31:0] normal_x,
	output logic signed [31:0] normal_y,
	output logic signed [10:0] neighbor_cell,
	output logic               degenerate
);
	import fgq_pkg::*;

	function automatic logic [4:0] norm_shift(input logic [32:0] v);
		logic [4:0] k;
		k = 5'd31;
		for (int i = 0; i <= 31; i++) begin
			if (v[i]) begin
				k = 5'(31 - i);
			end
		end
		if (v[32]) begin
			k = 5'd0;
		end
		return k;
	endfunction

	qpush_t             q_push;
	qitem_t             q_item;
	logic               q_vld;
	logic [QCW-1:0]     q_count;
	logic               en;

	logic               vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;
	logic signed [32:0] sx, sy;
	logic signed [31:0] mx_s1, my_s1, gx_s1, gy_s1;
	logic signed [32:0] dx_s1, dy_s1;
	logic signed [10:0] nbr_s1;
	logic [32:0]        ux_s2, uy_s2, ux_s3, uy_s3;
	tag_t               tag_s2, tag_s3, tag_s4, tag_s5, tag_s6;
	tag_t               tag_k;
	logic [65:0]        sqx_s3, sqy_s3, s_s4, s_s5, s_s6;
	logic [4:0]         k_s3;
	logic [65:0]        skx_s5, sky_s5, sk_s6;

	logic               sq_vld;
	logic [33:0]        sq_len, sq_lk;
	tag_t               sq_tag, dv_tag_in, dv_tag;
	logic               dv_vld;
	logic [30:0]        dv_qa, dv_qb;

	logic               vld_s7, vld_s8;
	logic signed [31:0] nx_s7, ny_s7, nx_s8, ny_s8;
	tag_t               tag_s7, tag_s8;
	logic signed [64:0] px_s8, py_s8;
	logic signed [65:0] dot;

	fgq_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid      (req_valid),
		.stall      (req_stall),
		.opcode     (opcode),
		.index      (index),
		.coord_x    (coord_x),
		.coord_y    (coord_y),
		.node_a     (node_a),
		.node_b     (node_b),
		.cell_a     (cell_a),
		.cell_b     (cell_b),
		.face_id    (face_id),
		.owner_cell (owner_cell),
		.q_count    (q_count),
		.push       (q_push)
	);

	fgq_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.pop      (en),
		.out_vld  (q_vld),
		.out_item (q_item),
		.count    (q_count)
	);

	assign en = !rsp_valid || !rsp_stall;

	assign sx = 33'(q_item.ax) + 33'(q_item.bx);
	assign sy = 33'(q_item.ay) + 33'(q_item.by);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			rsp_valid <= 1'b0;
		end else if (en) begin
			vld_s1 <= q_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
			vld_s7 <= dv_vld;
			vld_s8 <= vld_s7;
			rsp_valid <= vld_s8;
		end
	end

	always_comb begin
		tag_k    = tag_s3;
		tag_k.kx = ux_s3 << k_s3;
		tag_k.ky = uy_s3 << k_s3;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// floor of half sum, difference per axis
			mx_s1  <= sx[32:1];
			my_s1  <= sy[32:1];
			dx_s1  <= 33'(q_item.ax) - 33'(q_item.bx);
			dy_s1  <= 33'(q_item.ay) - 33'(q_item.by);
			gx_s1  <= q_item.gx;
			gy_s1  <= q_item.gy;
			nbr_s1 <= q_item.nbr;

			ux_s2        <= dx_s1[32] ? 33'(-dx_s1) : 33'(dx_s1);
			uy_s2        <= dy_s1[32] ? 33'(-dy_s1) : 33'(dy_s1);
			tag_s2.mx    <= mx_s1;
			tag_s2.my    <= my_s1;
			tag_s2.ex    <= 33'(mx_s1) - 33'(gx_s1);
			tag_s2.ey    <= 33'(my_s1) - 33'(gy_s1);
			tag_s2.neg_x <= !dy_s1[32] && dy_s1 != '0;
			tag_s2.neg_y <= dx_s1[32];
			tag_s2.degen <= dx_s1 == '0 && dy_s1 == '0;
			tag_s2.nbr   <= nbr_s1;
			tag_s2.kx    <= '0;
			tag_s2.ky    <= '0;
			tag_s2.len   <= '0;

			ux_s3  <= ux_s2;
			uy_s3  <= uy_s2;
			sqx_s3 <= 66'(ux_s2) * 66'(ux_s2);
			sqy_s3 <= 66'(uy_s2) * 66'(uy_s2);
			k_s3   <= norm_shift(ux_s2 | uy_s2);
			tag_s3 <= tag_s2;

			s_s4   <= sqx_s3 + sqy_s3;
			tag_s4 <= tag_k;

			s_s5   <= s_s4;
			skx_s5 <= 66'(tag_s4.kx) * 66'(tag_s4.kx);
			sky_s5 <= 66'(tag_s4.ky) * 66'(tag_s4.ky);
			tag_s5 <= tag_s4;

			s_s6   <= s_s5;
			sk_s6  <= skx_s5 + sky_s5;
			tag_s6 <= tag_s5;
		end
	end

	fgq_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (vld_s6),
		.s_a     (s_s6),
		.s_b     (sk_s6),
		.in_tag  (tag_s6),
		.out_vld (sq_vld),
		.root_a  (sq_len),
		.root_b  (sq_lk),
		.out_tag (sq_tag)
	);

	always_comb begin
		dv_tag_in     = sq_tag;
		dv_tag_in.len = sq_len[32:0];
	end

	fgq_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_vld  (sq_vld),
		.mag_a   (sq_tag.ky),
		.mag_b   (sq_tag.kx),
		.den     (sq_lk),
		.in_tag  (dv_tag_in),
		.out_vld (dv_vld),
		.q_a     (dv_qa),
		.q_b     (dv_qb),
		.out_tag (dv_tag)
	);

	assign dot = 66'(px_s8) + 66'(py_s8);

	always_ff @(posedge clk) begin
		if (en) begin
			if (dv_tag.degen) begin
				nx_s7 <= '0;
				ny_s7 <= '0;
			end else begin
				nx_s7 <= dv_tag.neg_x ? -$signed({1'b0, dv_qa}) : $signed({1'b0, dv_qa});
				ny_s7 <= dv_tag.neg_y ? -$signed({1'b0, dv_qb}) : $signed({1'b0, dv_qb});
			end
			tag_s7 <= dv_tag;

			px_s8  <= 65'(tag_s7.ex) * 65'(nx_s7);
			py_s8  <= 65'(tag_s7.ey) * 65'(ny_s7);
			nx_s8  <= nx_s7;
			ny_s8  <= ny_s7;
			tag_s8 <= tag_s7;

			mid_x         <= tag_s8.mx;
			mid_y         <= tag_s8.my;
			face_length   <= tag_s8.degen ? '0 : tag_s8.len;
			normal_x      <= dot[65] ? -nx_s8 : nx_s8;
			normal_y      <= dot[65] ? -ny_s8 : ny_s8;
			neighbor_cell <= tag_s8.nbr;
			degenerate    <= tag_s8.degen;
		end
	end

	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && degenerate |-> normal_x == '0 && normal_y == '0 && face_length == '0)
		else $error("degenerate result with nonzero normal or length");

	a_unit_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> normal_x <= NORM_ONE && normal_x >= -NORM_ONE
			&& normal_y <= NORM_ONE && normal_y >= -NORM_ONE)
		else $error("normal component beyond unit");

	a_queue_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_push.vld |-> q_count < QCW'(QDEPTH) || en)
		else $error("query queue overflow");

	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= QCW'(QDEPTH))
		else $error("queue count beyond depth");

endmodule

### tb/tb_face_geometry_query.sv
// tb_face_geometry_query: self-checking testbench for face_geometry_query. Directed table
// then random table loads and face queries, each checked by a predictor or a typed value.
// Depends on fgq_pkg and face_geometry_query.
module tb_face_geometry_query;
	import fgq_pkg::*;

	typedef struct {
		logic signed [31:0] mx;
		logic signed [31:0] my;
		logic [32:0]        len;
		logic signed [31:0] nx;
		logic signed [31:0] ny;
		logic signed [10:0] nbr;
		logic               dg;
	} geom_t;

	typedef struct {
		logic [1:0]         op;
		logic [9:0]         idx;
		logic signed [31:0] cx;
		logic signed [31:0] cy;
		logic [9:0]         na;
		logic [9:0]         nb;
		logic signed [10:0] ca;
		logic signed [10:0] cb;
		logic [9:0]         fc;
		logic [9:0]         ow;
		bit                 typed;
		geom_t              want;
		bit                 drain;
	} cmd_t;

	logic clk = 0;
	logic arst_n = 0;
	logic req_valid = 0, req_stall;
	logic [1:0] opcode = 0;
	logic [9:0] index = 0, node_a = 0, node_b = 0, face_id = 0, owner_cell = 0;
	logic signed [31:0] coord_x = 0, coord_y = 0;
	logic signed [10:0] cell_a = 0, cell_b = 0;
	logic rsp_valid, rsp_stall = 0;
	logic signed [31:0] mid_x, mid_y, normal_x, normal_y;
	logic [32:0] face_length;
	logic signed [10:0] neighbor_cell;
	logic degenerate;

	face_geometry_query dut (.*);

	always #2 clk = ~clk;

	// mesh tables as the predictor sees them, updated on accepted transfers
	logic signed [31:0] node_xy[1024][2];
	logic [9:0]         face_nodes[1024][2];
	logic signed [10:0] face_cells[1024][2];
	logic signed [31:0] cent_xy[1024][2];

	// node coordinates as generated, for coincident-node picks
	logic signed [31:0] gen_xy[1024][2];

	// which entries the stimulus has loaded so far
	bit node_ok[1024], face_ok[1024], cent_ok[1024];
	int node_list[$], cent_list[$], face_list[$];

	cmd_t  stim_q[$];
	geom_t geom_q[$];
	int    mismatches = 0, failures = 0, results_seen = 0;
	bit    rx_hold = 0, tx_done = 0;

	function automatic logic [63:0] hyp_round(logic [63:0] ux, logic [63:0] uy);
		logic [127:0] s, c, r;
		s = {64'd0, ux} * {64'd0, ux} + {64'd0, uy} * {64'd0, uy};
		r = 0;
		for (int b = 33; b >= 0; b--) begin
			c = r | (128'd1 << b);
			if (c * c <= s)
				r = c;
		end
		if (s > r * r + r)
			r = r + 1;
		return r[63:0];
	endfunction

	function automatic longint norm_comp(longint v, logic [63:0] den);
		logic [127:0] mag, q;
		mag = (v < 0) ? -v : v;
		q = (2 * (mag << 30) + den) / (2 * {64'd0, den});
		return (v < 0) ? -longint'(q) : longint'(q);
	endfunction

	function automatic geom_t face_geometry(logic [9:0] fc, logic [9:0] ow);
		geom_t g;
		longint ax, ay, bx, by, gx, gy, dx, dy, mx, my, nx, ny;
		logic [63:0] ux, uy, big, lk;
		logic signed [95:0] dot;
		int k;
		ax = node_xy[face_nodes[fc][0]][0];
		ay = node_xy[face_nodes[fc][0]][1];
		bx = node_xy[face_nodes[fc][1]][0];
		by = node_xy[face_nodes[fc][1]][1];
		gx = cent_xy[ow][0];
		gy = cent_xy[ow][1];
		mx = (ax + bx) >>> 1;
		my = (ay + by) >>> 1;
		dx = ax - bx;
		dy = ay - by;
		ux = (dx < 0) ? -dx : dx;
		uy = (dy < 0) ? -dy : dy;
		nx = 0;
		ny = 0;
		g.len = 0;
		g.dg = (ux == 0 && uy == 0);
		if (!g.dg) begin
			g.len = hyp_round(ux, uy);
			big = (ux > uy) ? ux : uy;
			k = 0;
			while ((big << k) < 64'h8000_0000)
				k++;
			lk = hyp_round(ux << k, uy << k);
			nx = norm_comp(-(dy <<< k), lk);
			ny = norm_comp(dx <<< k, lk);
			dot = 96'(mx - gx) * 96'(nx) + 96'(my - gy) * 96'(ny);
			if (dot < 0) begin
				nx = -nx;
				ny = -ny;
			end
		end
		g.mx = mx[31:0];
		g.my = my[31:0];
		g.nx = nx[31:0];
		g.ny = ny[31:0];
		g.nbr = (int'(face_cells[fc][0]) != int'(ow)) ? face_cells[fc][0] : face_cells[fc][1];
		return g;
	endfunction

	function automatic void note_load(cmd_t c);
		case (c.op)
			OP_NODE: if (!node_ok[c.idx]) begin
				node_ok[c.idx] = 1;
				node_list.insert(node_list.size(), c.idx);
			end
			OP_FACE: if (!face_ok[c.idx]) begin
				face_ok[c.idx] = 1;
				face_list.insert(face_list.size(), c.idx);
			end
			OP_CENT: if (!cent_ok[c.idx]) begin
				cent_ok[c.idx] = 1;
				cent_list.insert(cent_list.size(), c.idx);
			end
			default: ;
		endcase
	endfunction

	function automatic void add_row(logic [1:0] op, int idx, int cx, int cy, int na, int nb,
			int ca, int cb, int fc, int ow, bit typed, geom_t want);
		cmd_t c;
		c = '{op, 10'(idx), cx, cy, 10'(na), 10'(nb), 11'(ca), 11'(cb), 10'(fc), 10'(ow),
			typed, want, 0};
		note_load(c);
		stim_q.insert(stim_q.size(), c);
	endfunction

	function automatic int rand_coord();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
			1, 2: return $signed($urandom_range(0, 32'h1f_ffff)) - 32'sh10_0000;
			default: return $urandom;
		endcase
	endfunction

	function automatic int rand_cell();
		int r;
		r = $urandom_range(0, 9);
		if (r < 2)
			return -1;
		if (r < 7 && cent_list.size() > 0)
			return cent_list[$urandom_range(0, cent_list.size() - 1)];
		return $urandom_range(0, 1023);
	endfunction

	function automatic void add_random();
		cmd_t c;
		int r, f;
		r = $urandom_range(0, 99);
		c.idx = 10'($urandom);
		c.cx = rand_coord();
		c.cy = rand_coord();
		c.na = 10'($urandom);
		c.nb = 10'($urandom);
		c.ca = 11'($urandom);
		c.cb = 11'($urandom);
		c.fc = 10'($urandom);
		c.ow = 10'($urandom);
		c.typed = 0;
		c.drain = 0;
		if (node_list.size() < 2 || r < 15) begin
			c.op = OP_NODE;
			if ($urandom_range(0, 9) == 0 && node_list.size() > 0) begin
				f = node_list[$urandom_range(0, node_list.size() - 1)];
				c.cx = gen_xy[f][0];
				c.cy = gen_xy[f][1];
			end
		end else if (face_list.size() == 0 || r < 30) begin
			c.op = OP_FACE;
			c.na = 10'(node_list[$urandom_range(0, node_list.size() - 1)]);
			c.nb = ($urandom_range(0, 15) == 0) ? c.na :
				10'(node_list[$urandom_range(0, node_list.size() - 1)]);
			c.ca = 11'(rand_cell());
			c.cb = 11'(rand_cell());
		end else if (cent_list.size() == 0 || r < 40) begin
			c.op = OP_CENT;
		end else begin
			c.op = OP_QUERY;
			c.fc = 10'(face_list[$urandom_range(0, face_list.size() - 1)]);
			f = stim_q.size();
			c.ow = 10'(cent_list[$urandom_range(0, cent_list.size() - 1)]);
			// owner often equal to one side of the face
			for (int i = f - 1; i >= 0; i--)
				if (stim_q[i].op == OP_FACE && stim_q[i].idx == c.fc) begin
					if ($urandom_range(0, 1) && stim_q[i].ca >= 0 && cent_ok[stim_q[i].ca])
						c.ow = 10'(stim_q[i].ca);
					else if ($urandom_range(0, 1) && stim_q[i].cb >= 0 &&
							cent_ok[stim_q[i].cb])
						c.ow = 10'(stim_q[i].cb);
					break;
				end
		end
		note_load(c);
		stim_q.insert(stim_q.size(), c);
	endfunction

	// accepted loads update the predictor tables; queries queue their expected result
	function automatic void apply_load(cmd_t c);
		case (c.op)
			OP_NODE: begin
				node_xy[c.idx][0] = c.cx;
				node_xy[c.idx][1] = c.cy;
			end
			OP_FACE: begin
				face_nodes[c.idx][0] = c.na;
				face_nodes[c.idx][1] = c.nb;
				face_cells[c.idx][0] = c.ca;
				face_cells[c.idx][1] = c.cb;
			end
			OP_CENT: begin
				cent_xy[c.idx][0] = c.cx;
				cent_xy[c.idx][1] = c.cy;
			end
			default: geom_q.insert(geom_q.size(), c.typed ? c.want : face_geometry(c.fc, c.ow));
		endcase
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	initial begin
		geom_t z, w;
		cmd_t c;
		int g;
		bit calm;
		z = '{0, 0, 0, 0, 0, 0, 0};
		add_row(OP_NODE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, z);
		add_row(OP_NODE, 1, 32'h1_0000, 0, 0, 0, 0, 0, 0, 0, 0, z);
		add_row(OP_NODE, 1023, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 0, 0, 0, 0, 0, z);
		add_row(OP_NODE, 2, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0, 0, 0, 0, z);
		add_row(OP_NODE, 3, 32'h8000_0000, 32'h7fff_ffff, 0, 0, 0, 0, 0, 0, 0, z);
		add_row(OP_CENT, 0, 0, -32'sh1_0000, 0, 0, 0, 0, 0, 0, 0, z);
		add_row(OP_CENT, 1023, 0, 0, 0, 0, 0, 0, 0, 0, 0, z);
		add_row(OP_FACE, 0, 0, 0, 0, 1, 0, -1, 0, 0, 0, z);
		add_row(OP_FACE, 1023, 0, 0, 2, 1023, 1023, 1023, 0, 0, 0, z);
		add_row(OP_FACE, 1, 0, 0, 0, 0, -1, 0, 0, 0, 0, z);
		add_row(OP_FACE, 2, 0, 0, 3, 1023, 0, 1023, 0, 0, 0, z);
		add_row(OP_FACE, 3, 0, 0, 2, 3, 1023, -1, 0, 0, 0, z);
		w = '{32'sh8000, 0, 33'h1_0000, 0, NORM_ONE, -1, 0};
		add_row(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, w);
		w = '{0, 0, 0, 0, 0, -1, 1};
		add_row(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 1, 0, 1, w);
		add_row(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 1023, 1023, 0, z);
		add_row(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 1023, 0, 0, z);
		add_row(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 2, 0, 0, z);
		add_row(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 2, 1023, 0, z);
		add_row(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 3, 1023, 0, z);
		add_row(OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 1023, 0, z);
		// generation-time node copy so random coincident nodes can copy coordinates
		foreach (stim_q[i])
			if (stim_q[i].op == OP_NODE) begin
				gen_xy[stim_q[i].idx][0] = stim_q[i].cx;
				gen_xy[stim_q[i].idx][1] = stim_q[i].cy;
			end
		for (int i = 0; i < 880; i++) begin
			add_random();
			if (stim_q[$].op == OP_NODE) begin
				gen_xy[stim_q[$].idx][0] = stim_q[$].cx;
				gen_xy[stim_q[$].idx][1] = stim_q[$].cy;
			end
		end
		stim_q[450].drain = 1;

		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		calm = 0;
		for (int i = 0; i < stim_q.size(); i++) begin
			c = stim_q[i];
			if (i % 100 == 0)
				calm = $urandom_range(0, 2) == 0;
			g = (calm || rx_hold) ? 0 : gap_len();
			if (c.drain) begin
				req_valid <= 0;
				@(posedge clk);
				while (geom_q.size() != 0)
					@(posedge clk);
			end else if (g > 0) begin
				req_valid <= 0;
				repeat (g) @(posedge clk);
			end
			req_valid <= 1;
			opcode <= c.op;
			index <= c.idx;
			coord_x <= c.cx;
			coord_y <= c.cy;
			node_a <= c.na;
			node_b <= c.nb;
			cell_a <= c.ca;
			cell_b <= c.cb;
			face_id <= c.fc;
			owner_cell <= c.ow;
			do @(posedge clk); while (req_stall);
			apply_load(c);
		end
		req_valid <= 0;
		tx_done = 1;
	end

	initial begin
		bit calm;
		int g;
		geom_t e;
		calm = 0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (rsp_valid && !rsp_stall) begin
				results_seen++;
				if (geom_q.size() == 0) begin
					failures++;
					if (mismatches++ < 10)
						$display("unexpected result transfer at %0t", $time);
				end else begin
					e = geom_q.pop_front();
					if (mid_x !== e.mx || mid_y !== e.my || face_length !== e.len ||
							normal_x !== e.nx || normal_y !== e.ny ||
							neighbor_cell !== e.nbr || degenerate !== e.dg) begin
						failures++;
						if (mismatches++ < 10)
							$display({"mismatch: exp mid %0d,%0d len %0d n %0d,%0d ",
								"nbr %0d dg %0d / got mid %0d,%0d len %0d n %0d,%0d ",
								"nbr %0d dg %0d"},
								e.mx, e.my, e.len, e.nx, e.ny, e.nbr, e.dg, mid_x,
								mid_y, face_length, normal_x, normal_y, neighbor_cell,
								degenerate);
					end
				end
				if (results_seen == 120) begin
					rx_hold = 1;
					rsp_stall <= 1;
					for (int n = 0; n < 400; n++)
						@(posedge clk);
					rx_hold = 0;
					rsp_stall <= 0;
					continue;
				end
			end
			if (results_seen % 80 == 0)
				calm = $urandom_range(0, 2) == 0;
			g = calm ? 0 : gap_len();
			if (g > 0) begin
				rsp_stall <= 1;
				repeat (g) @(posedge clk);
				rsp_stall <= 0;
			end
		end
	end

	initial begin
		wait (tx_done);
		while (geom_q.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (failures == 0)
			$display("[face_geometry_query] OK");
		else
			$display("[face_geometry_query] ERROR");
		$finish;
	end

	initial begin
		#4000000;
		$display("[face_geometry_query] ERROR");
		$finish;
	end

endmodule
